/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Every macro samples on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The condition must never be true.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`endif

/* hdl/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg
// Types, constants and the microcode table of the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

    // Matrix geometry.
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    // Input item modes.
    localparam logic [1:0] MODE_LEFT    = 2'd0;
    localparam logic [1:0] MODE_RIGHT   = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_RIGHT_COLS = 2'd2;

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ISSUE   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN_A = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN_B = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd4;

    // Branch conditions.
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_START    = 2'd1;
    localparam logic [1:0] COND_K_LAST   = 2'd2;
    localparam logic [1:0] COND_OUT_FREE = 2'd3;

    // Sizes held in the configuration registers.
    typedef struct packed {
        logic [DIM_W-1:0] left_rows;
        logic [DIM_W-1:0] inner_size;
        logic [DIM_W-1:0] right_cols;
    } dims_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic              accept;
        logic              clr_all;
        logic              issue;
        logic              emit;
        logic              end_on_last;
        logic [1:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } ctl_word_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic start;
        logic k_last;
        logic out_free;
        logic entry_last;
    } status_t;

    // Clamp a size register value into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] imm_clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Microcode ROM.
    function automatic ctl_word_t imm_ucode(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.accept    = 1'b1;
                w.clr_all   = 1'b1;
                w.cond      = COND_START;
                w.tgt_true  = STEP_ISSUE;
                w.tgt_false = STEP_IDLE;
            end
            STEP_ISSUE:
            begin
                w.issue     = 1'b1;
                w.cond      = COND_K_LAST;
                w.tgt_true  = STEP_DRAIN_A;
                w.tgt_false = STEP_ISSUE;
            end
            STEP_DRAIN_A:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_DRAIN_B;
                w.tgt_false = STEP_DRAIN_B;
            end
            STEP_DRAIN_B:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_EMIT;
                w.tgt_false = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit        = 1'b1;
                w.end_on_last = 1'b1;
                w.cond        = COND_OUT_FREE;
                w.tgt_true    = STEP_ISSUE;
                w.tgt_false   = STEP_EMIT;
            end
            default:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = STEP_IDLE;
                w.tgt_false = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/integer_matrix_multiply_top.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top: integer matrix product engine.
// Load transactions are accepted back to back in idle.
// A compute transaction emits left_rows*right_cols entries, each built from
// one multiply-accumulate per cycle plus the read and multiply pipe drain.
// Reset sets all size registers to 8; the stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_matrix_multiply_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [imm_pkg::IDX_W-1:0]         row_index,
    input  logic [imm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [imm_pkg::DATA_W-1:0] entry_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [imm_pkg::IDX_W-1:0]         out_row,
    output logic [imm_pkg::IDX_W-1:0]         out_col,
    output logic signed [imm_pkg::DATA_W-1:0] product_value,
    output logic                              last_entry
);

    imm_pkg::dims_t     dims_reg;
    imm_pkg::ctl_word_t ctl;
    imm_pkg::status_t   stat;
    logic               compute_fire;
    logic               dims_zero;

    // Configuration writes are always accepted; values are clamped on entry.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.left_rows  <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
            dims_reg.inner_size <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
            dims_reg.right_cols <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                imm_pkg::CFG_LEFT_ROWS:  dims_reg.left_rows  <= imm_pkg::imm_clamp_dim(cfg_data);
                imm_pkg::CFG_INNER_SIZE: dims_reg.inner_size <= imm_pkg::imm_clamp_dim(cfg_data);
                imm_pkg::CFG_RIGHT_COLS: dims_reg.right_cols <= imm_pkg::imm_clamp_dim(cfg_data);
                default:                 dims_reg            <= dims_reg;
            endcase
        end
    end

    // The input side is open only in the idle step of the microprogram.
    assign in_ready = ctl.accept;

    imm_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    imm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .dims          (dims_reg),
        .stat          (stat),
        .in_valid      (in_valid),
        .mode          (mode),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last_entry    (last_entry)
    );

    // Conditions watched by the assertions below.
    assign compute_fire = in_valid && in_ready && (mode == imm_pkg::MODE_COMPUTE);
    assign dims_zero    = (dims_reg.left_rows == '0) || (dims_reg.inner_size == '0)
        || (dims_reg.right_cols == '0);

    // A compute transaction closes the input side for the whole run.
    `ASSERT_NEXT(a_compute_locks_input, compute_fire, !in_ready)

    // While entries of a run are still to come, the block stays busy.
    `ASSERT_IMPLIES(a_busy_until_last, out_valid && out_ready && !last_entry, !in_ready)

    // Sizes never leave their legal range.
    `ASSERT_NEVER(a_dims_zero, dims_zero)

    // Multiply-accumulate work happens only outside the idle step.
    `ASSERT_NEVER(a_issue_in_idle, ctl.issue && ctl.accept)

endmodule

/* hdl/imm_ram.sv */
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/imm_sequencer.sv */
// ----------------------------------------------------------------------------
// imm_sequencer
// Step counter and branch unit that fetches control words from the microcode.
// ----------------------------------------------------------------------------
module imm_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  imm_pkg::status_t   stat,
    output imm_pkg::ctl_word_t ctl
);

    logic [imm_pkg::STEP_W-1:0] pc_reg;
    logic [imm_pkg::STEP_W-1:0] pc_next;
    logic                       cond_ok;

    // Fetch the control word of the current step.
    assign ctl = imm_pkg::imm_ucode(pc_reg);

    // Evaluate the branch condition selected by the control word.
    always_comb
    begin
        unique case (ctl.cond)
            imm_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            imm_pkg::COND_START:    cond_ok = stat.start;
            imm_pkg::COND_K_LAST:   cond_ok = stat.k_last;
            imm_pkg::COND_OUT_FREE: cond_ok = stat.out_free;
        endcase
    end

    // Choose the next step; the final emitted entry returns to idle.
    always_comb
    begin
        if (!cond_ok)
        begin
            pc_next = ctl.tgt_false;
        end
        else if (ctl.end_on_last && stat.entry_last)
        begin
            pc_next = imm_pkg::STEP_IDLE;
        end
        else
        begin
            pc_next = ctl.tgt_true;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= imm_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/imm_datapath.sv */
// ----------------------------------------------------------------------------
// imm_datapath
// Matrix stores, index counters, multiply-accumulate pipe and output register.
// ----------------------------------------------------------------------------
module imm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  imm_pkg::ctl_word_t                ctl,
    input  imm_pkg::dims_t                    dims,
    output imm_pkg::status_t                  stat,
    input  logic                              in_valid,
    input  logic [1:0]                        mode,
    input  logic [imm_pkg::IDX_W-1:0]         row_index,
    input  logic [imm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [imm_pkg::DATA_W-1:0] entry_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [imm_pkg::IDX_W-1:0]         out_row,
    output logic [imm_pkg::IDX_W-1:0]         out_col,
    output logic signed [imm_pkg::DATA_W-1:0] product_value,
    output logic                              last_entry
);

    logic                          in_fire;
    logic                          emit_fire;
    logic                          row_last;
    logic [imm_pkg::IDX_W-1:0]     r_reg;
    logic [imm_pkg::IDX_W-1:0]     c_reg;
    logic [imm_pkg::IDX_W-1:0]     k_reg;
    logic                          rd_v_reg;
    logic                          prod_v_reg;
    logic [imm_pkg::DATA_W-1:0]    prod_reg;
    logic [imm_pkg::DATA_W-1:0]    prod_next;
    logic [imm_pkg::DATA_W-1:0]    acc_reg;
    logic [imm_pkg::DATA_W-1:0]    left_rdata;
    logic [imm_pkg::DATA_W-1:0]    right_rdata;
    logic [imm_pkg::ADDR_W-1:0]    waddr;
    logic                          left_we;
    logic                          right_we;
    logic                          out_valid_reg;
    logic [imm_pkg::IDX_W-1:0]     out_row_reg;
    logic [imm_pkg::IDX_W-1:0]     out_col_reg;
    logic [imm_pkg::DATA_W-1:0]    out_value_reg;
    logic                          out_last_reg;

    // Input transaction and store writes.
    assign in_fire  = in_valid && ctl.accept;
    assign waddr    = {row_index, col_index};
    assign left_we  = in_fire && (mode == imm_pkg::MODE_LEFT);
    assign right_we = in_fire && (mode == imm_pkg::MODE_RIGHT);

    // Status for the sequencer.
    assign row_last        = {1'b0, r_reg} == (dims.left_rows - imm_pkg::DIM_W'(1));
    assign stat.start      = in_fire && (mode == imm_pkg::MODE_COMPUTE);
    assign stat.k_last     = {1'b0, k_reg} == (dims.inner_size - imm_pkg::DIM_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.entry_last = row_last
        && ({1'b0, c_reg} == (dims.right_cols - imm_pkg::DIM_W'(1)));
    assign emit_fire       = ctl.emit && stat.out_free;

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (imm_pkg::DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (left_we),
        .waddr (waddr),
        .wdata (entry_value),
        .raddr ({r_reg, k_reg}),
        .rdata (left_rdata)
    );

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (imm_pkg::DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (right_we),
        .waddr (waddr),
        .wdata (entry_value),
        .raddr ({k_reg, c_reg}),
        .rdata (right_rdata)
    );

    // Index counters: k walks the inner dimension, r and c walk the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
        end
        else if (ctl.clr_all)
        begin
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
        end
        else if (emit_fire)
        begin
            k_reg <= '0;
            if (row_last)
            begin
                r_reg <= '0;
                c_reg <= c_reg + imm_pkg::IDX_W'(1);
            end
            else
            begin
                r_reg <= r_reg + imm_pkg::IDX_W'(1);
            end
        end
        else if (ctl.issue)
        begin
            k_reg <= k_reg + imm_pkg::IDX_W'(1);
        end
    end

    // Valid flags that follow each read through the multiply pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= ctl.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    // Low 32 bits of the product are the same for signed and unsigned operands.
    assign prod_next = left_rdata * right_rdata;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Accumulator, cleared in idle and when an entry leaves for the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.clr_all || emit_fire)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg   <= r_reg;
            out_col_reg   <= c_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= stat.entry_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_value_reg;
    assign last_entry    = out_last_reg;

endmodule
